// ===== hw/rtl/tsi_pkg.sv =====
`default_nettype none
package tsi_pkg;

    localparam int TSI_MAX_TRIANGLES = 128;
    localparam int TSI_COORD_BITS    = 16;
    localparam int APB_ADDR_W        = 5;
    localparam int APB_DATA_W        = 32;
    localparam int NUM_SEED_REGS     = 6;

    localparam int SEED_RESET [NUM_SEED_REGS] = '{-4096, -4096, 8192, -4096, 2048, 8192};

    typedef enum logic [2:0] {
        REG_SEED_AX,
        REG_SEED_AY,
        REG_SEED_BX,
        REG_SEED_BY,
        REG_SEED_CX,
        REG_SEED_CY
    } t_reg;

    typedef enum logic [1:0] {
        OP_START,
        OP_INSERT,
        OP_READ
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_MISS,
        STATUS_FULL
    } t_status;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SEED,
        WR_HIT,
        WR_NEW0,
        WR_NEW1
    } t_wr_sel;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_SEED,
        EM_SPLIT,
        EM_FULL,
        EM_MISS,
        EM_READ
    } t_emit;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_HIT,
        ST_WR1,
        ST_WR2,
        ST_READ,
        ST_READ_OUT
    } t_state;

    typedef struct packed {
        logic    load_item;
        logic    scan;
        logic    capture;
        logic    rd_ridx;
        t_wr_sel wr_sel;
        t_emit   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic full;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== hw/rtl/tsi_regs.sv =====
`default_nettype none
module tsi_regs
    import tsi_pkg::*;
#(
    parameter int COORD_BITS = TSI_COORD_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [APB_ADDR_W-1:0]               paddr,
    input  wire logic [APB_DATA_W-1:0]               pwdata,
    output logic      [APB_DATA_W-1:0]               prdata,
    output logic                                     pready,
    output logic      [NUM_SEED_REGS-1:0][COORD_BITS-1:0] o_seed
);

    logic [NUM_SEED_REGS-1:0][COORD_BITS-1:0] r_seed;
    logic [2:0]                               idx;
    logic                                     wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_seed = r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SEED_REGS; k++) begin
                r_seed[k] <= COORD_BITS'(SEED_RESET[k]);
            end
        end else if (wr && idx <= REG_SEED_CY) begin
            r_seed[idx] <= pwdata[COORD_BITS-1:0];
        end
    end

    always_comb begin
        if (idx <= REG_SEED_CY) begin
            prdata = APB_DATA_W'($signed(r_seed[idx]));
        end else begin
            prdata = '0;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tsi_ctrl.sv =====
`default_nettype none
module tsi_ctrl
    import tsi_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_opcode,
    input  wire t_dp_status i_st,
    output logic            o_busy,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd.load_item = 1'b0;
        o_cmd.scan      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.rd_ridx   = 1'b0;
        o_cmd.wr_sel    = WR_NONE;
        o_cmd.emit      = EM_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    case (i_opcode)
                        OP_START:  n_state = ST_SEED;
                        OP_INSERT: n_state = ST_SCAN;
                        OP_READ:   n_state = ST_READ;
                        default:   o_cmd.emit = EM_MISS;
                    endcase
                end
            end
            ST_SEED: begin
                o_cmd.wr_sel = WR_SEED;
                o_cmd.emit   = EM_SEED;
                n_state      = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_st.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_HIT;
                end else if (i_st.scan_done) begin
                    o_cmd.emit = EM_MISS;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_HIT: begin
                if (i_st.full) begin
                    o_cmd.emit = EM_FULL;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.wr_sel = WR_HIT;
                    n_state      = ST_WR1;
                end
            end
            ST_WR1: begin
                o_cmd.wr_sel = WR_NEW0;
                n_state      = ST_WR2;
            end
            ST_WR2: begin
                o_cmd.wr_sel = WR_NEW1;
                o_cmd.emit   = EM_SPLIT;
                n_state      = ST_IDLE;
            end
            ST_READ: begin
                o_cmd.rd_ridx = 1'b1;
                n_state       = ST_READ_OUT;
            end
            ST_READ_OUT: begin
                o_cmd.emit = EM_READ;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tsi_dp.sv =====
`default_nettype none
module tsi_dp
    import tsi_pkg::*;
#(
    parameter int MAX_TRIANGLES = TSI_MAX_TRIANGLES,
    parameter int COORD_BITS    = TSI_COORD_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire t_dp_cmd                                 i_cmd,
    input  wire logic [COORD_BITS-1:0]                   i_point_x,
    input  wire logic [COORD_BITS-1:0]                   i_point_y,
    input  wire logic [6:0]                              i_read_index,
    input  wire logic [NUM_SEED_REGS-1:0][COORD_BITS-1:0] i_seed,
    output t_dp_status                                   o_st,
    output logic                                         o_strobe,
    output logic [1:0]                                   o_status,
    output logic [6:0]                                   o_hit_index,
    output logic [7:0]                                   o_triangle_count,
    output logic [NUM_SEED_REGS-1:0][COORD_BITS-1:0]     o_tri
);

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_TRIANGLES);
    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
    localparam int DW    = CB + 1;
    localparam int PW    = 2 * DW;
    localparam int ND    = 12;
    localparam int NP    = 8;

    typedef logic [NUM_SEED_REGS-1:0][CB-1:0] t_tri;

    function automatic logic signed [DW-1:0] sub(input logic [CB-1:0] x,
                                                input logic [CB-1:0] y);
        sub = $signed({x[CB-1], x}) - $signed({y[CB-1], y});
    endfunction

    logic [CB-1:0]    r_px;
    logic [CB-1:0]    r_py;
    logic [6:0]       r_ridx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] cnt_plus1;
    logic [CNT_W-1:0] r_scan_addr;
    logic             issue;

    t_tri             mem [MAX_TRIANGLES];
    t_tri             r_rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    t_tri             wr_data;
    logic             wr_en;

    logic             r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld;
    logic [IDX_W-1:0] r_s0_idx, r_s1_idx, r_s2_idx, r_s3_idx;
    t_tri             r_s1_tri, r_s2_tri, r_s3_tri;
    logic signed [DW-1:0] d   [ND];
    logic signed [DW-1:0] r_d [ND];
    logic signed [PW-1:0] r_p [NP];
    logic signed [PW-1:0] e_d, e_1, e_2, e_3;
    logic             in_tri;
    logic             r_s3_in;

    logic [IDX_W-1:0] r_hit_idx;
    t_tri             r_hit_tri;

    logic [IDX_W+6:0] ridx_ext;
    logic [IDX_W-1:0] ridx_addr;
    logic             ridx_ok;
    logic [IDX_W+6:0] hit_ext;
    logic [CNT_W+7:0] cnt_ext;

    logic             r_strobe;
    logic [1:0]       r_o_status;
    logic [6:0]       r_o_hit;
    logic [7:0]       r_o_cnt;
    t_tri             r_o_tri;

    assign ridx_ext  = {{IDX_W{1'b0}}, r_ridx};
    assign ridx_addr = ridx_ext[IDX_W-1:0];
    assign ridx_ok   = ({{CNT_W{1'b0}}, r_ridx} < {7'b0, r_count});
    assign hit_ext   = {7'b0, r_hit_idx};
    assign cnt_ext   = {8'b0, n_count};
    assign cnt_plus1 = r_count + CNT_W'(1);
    assign issue     = i_cmd.scan && (r_scan_addr < r_count);
    assign rd_addr   = i_cmd.rd_ridx ? ridx_addr : r_scan_addr[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = r_hit_tri;
        n_count = r_count;
        case (i_cmd.wr_sel)
            WR_SEED: begin
                wr_data = i_seed;
                n_count = CNT_W'(1);
            end
            WR_HIT: begin
                wr_addr    = r_hit_idx;
                wr_data[4] = r_px;
                wr_data[5] = r_py;
            end
            WR_NEW0: begin
                wr_addr    = r_count[IDX_W-1:0];
                wr_data[0] = r_px;
                wr_data[1] = r_py;
            end
            WR_NEW1: begin
                wr_addr    = cnt_plus1[IDX_W-1:0];
                wr_data[2] = r_px;
                wr_data[3] = r_py;
                n_count    = r_count + CNT_W'(2);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan_addr <= '0;
            r_s0_vld    <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_item) begin
                r_scan_addr <= '0;
                r_s0_vld    <= 1'b0;
                r_s1_vld    <= 1'b0;
                r_s2_vld    <= 1'b0;
                r_s3_vld    <= 1'b0;
            end else begin
                if (issue) begin
                    r_scan_addr <= r_scan_addr + CNT_W'(1);
                end
                r_s0_vld <= issue;
                r_s1_vld <= r_s0_vld;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_ridx <= i_read_index;
        end
        if (i_cmd.capture) begin
            r_hit_idx <= r_s3_idx;
            r_hit_tri <= r_s3_tri;
        end
    end

    always_comb begin
        d[0]  = sub(r_rd_data[2], r_rd_data[0]);
        d[1]  = sub(r_rd_data[5], r_rd_data[1]);
        d[2]  = sub(r_rd_data[3], r_rd_data[1]);
        d[3]  = sub(r_rd_data[4], r_rd_data[0]);
        d[4]  = sub(r_py,         r_rd_data[1]);
        d[5]  = sub(r_px,         r_rd_data[0]);
        d[6]  = sub(r_rd_data[2], r_rd_data[4]);
        d[7]  = sub(r_py,         r_rd_data[5]);
        d[8]  = sub(r_rd_data[3], r_rd_data[5]);
        d[9]  = sub(r_px,         r_rd_data[4]);
        d[10] = sub(r_rd_data[0], r_rd_data[4]);
        d[11] = sub(r_rd_data[1], r_rd_data[5]);
    end

    always_comb begin
        e_d = r_p[0] - r_p[1];
        e_1 = r_p[2] - r_p[3];
        e_2 = r_p[4] - r_p[5];
        e_3 = r_p[6] - r_p[7];
        in_tri = (e_d == '0) ||
                 (((e_1 == '0) || (e_1[PW-1] == e_d[PW-1])) &&
                  ((e_2 == '0) || (e_2[PW-1] != e_d[PW-1])) &&
                  ((e_3 == '0) || (e_3[PW-1] == e_d[PW-1])));
    end

    always_ff @(posedge i_clk) begin
        r_s0_idx <= r_scan_addr[IDX_W-1:0];
        r_s1_idx <= r_s0_idx;
        r_s2_idx <= r_s1_idx;
        r_s3_idx <= r_s2_idx;
        r_s1_tri <= r_rd_data;
        r_s2_tri <= r_s1_tri;
        r_s3_tri <= r_s2_tri;
        for (int k = 0; k < ND; k++) begin
            r_d[k] <= d[k];
        end
        r_p[0] <= r_d[0]  * r_d[1];
        r_p[1] <= r_d[2]  * r_d[3];
        r_p[2] <= r_d[0]  * r_d[4];
        r_p[3] <= r_d[2]  * r_d[5];
        r_p[4] <= r_d[6]  * r_d[7];
        r_p[5] <= r_d[8]  * r_d[9];
        r_p[6] <= r_d[10] * r_d[7];
        r_p[7] <= r_d[11] * r_d[9];
        r_s3_in <= in_tri;
    end

    assign o_st.hit       = r_s3_vld && r_s3_in;
    assign o_st.scan_done = !(r_scan_addr < r_count) &&
                            !r_s0_vld && !r_s1_vld && !r_s2_vld && !r_s3_vld;
    assign o_st.full      = ({1'b0, r_count} + (CNT_W+1)'(2)) > (CNT_W+1)'(MAX_TRIANGLES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.emit != EM_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EM_SEED: begin
                r_o_status <= STATUS_OK;
                r_o_hit    <= '0;
                r_o_cnt    <= cnt_ext[7:0];
                r_o_tri    <= i_seed;
            end
            EM_SPLIT: begin
                r_o_status <= STATUS_OK;
                r_o_hit    <= hit_ext[6:0];
                r_o_cnt    <= cnt_ext[7:0];
                r_o_tri    <= r_hit_tri;
            end
            EM_FULL: begin
                r_o_status <= STATUS_FULL;
                r_o_hit    <= hit_ext[6:0];
                r_o_cnt    <= cnt_ext[7:0];
                r_o_tri    <= r_hit_tri;
            end
            EM_MISS: begin
                r_o_status <= STATUS_MISS;
                r_o_hit    <= '0;
                r_o_cnt    <= cnt_ext[7:0];
                r_o_tri    <= '0;
            end
            EM_READ: begin
                r_o_hit <= r_ridx;
                r_o_cnt <= cnt_ext[7:0];
                if (ridx_ok) begin
                    r_o_status <= STATUS_OK;
                    r_o_tri    <= r_rd_data;
                end else begin
                    r_o_status <= STATUS_MISS;
                    r_o_tri    <= '0;
                end
            end
            default: begin
                r_o_status <= r_o_status;
            end
        endcase
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_o_status;
    assign o_hit_index      = r_o_hit;
    assign o_triangle_count = r_o_cnt;
    assign o_tri            = r_o_tri;

endmodule
`default_nettype wire

// ===== hw/rtl/triangle_split_insert_unit.sv =====
`default_nettype none
// Triangle table with point insertion. Pulse start while busy is low with an opcode:
// start seeds slot 0 from the seed registers, read returns one slot, insert scans the
// stored triangles in slot order, one per cycle through a four-stage containment
// pipeline fed by the single table read port, and splits the first hit with three table
// writes, or answers with full status when two more triangles would not fit, and with
// miss status when no stored triangle contains the point. An unknown opcode answers on
// the next cycle. Each result is on the o_ ports for one cycle with o_strobe high and
// there is no way to stall it. Table contents are undefined until the first start.
module triangle_split_insert_unit
    import tsi_pkg::*;
#(
    parameter int MAX_TRIANGLES = TSI_MAX_TRIANGLES,
    parameter int COORD_BITS    = TSI_COORD_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             i_opcode,
    input  wire logic [COORD_BITS-1:0]  i_point_x,
    input  wire logic [COORD_BITS-1:0]  i_point_y,
    input  wire logic [6:0]             i_read_index,
    output logic                        o_strobe,
    output logic [1:0]                  o_status,
    output logic [6:0]                  o_hit_index,
    output logic [7:0]                  o_triangle_count,
    output logic [COORD_BITS-1:0]       o_out_ax,
    output logic [COORD_BITS-1:0]       o_out_ay,
    output logic [COORD_BITS-1:0]       o_out_bx,
    output logic [COORD_BITS-1:0]       o_out_by,
    output logic [COORD_BITS-1:0]       o_out_cx,
    output logic [COORD_BITS-1:0]       o_out_cy
);

    logic [NUM_SEED_REGS-1:0][COORD_BITS-1:0] seed;
    logic [NUM_SEED_REGS-1:0][COORD_BITS-1:0] tri_out;
    t_dp_cmd    cmd;
    t_dp_status dp_st;

    tsi_regs #(
        .COORD_BITS(COORD_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (seed)
    );

    tsi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_st     (dp_st),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    tsi_dp #(
        .MAX_TRIANGLES(MAX_TRIANGLES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_read_index     (i_read_index),
        .i_seed           (seed),
        .o_st             (dp_st),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_hit_index      (o_hit_index),
        .o_triangle_count (o_triangle_count),
        .o_tri            (tri_out)
    );

    assign o_out_ax = tri_out[0];
    assign o_out_ay = tri_out[1];
    assign o_out_bx = tri_out[2];
    assign o_out_by = tri_out[3];
    assign o_out_cx = tri_out[4];
    assign o_out_cy = tri_out[5];

endmodule
`default_nettype wire

// ===== hw/rtl/tsi_checker.sv =====
`default_nettype none
module tsi_checker
    import tsi_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_opcode,
    input wire logic [6:0] i_read_index,
    input wire logic       o_strobe,
    input wire logic [1:0] o_status,
    input wire logic [6:0] o_hit_index,
    input wire logic [7:0] o_triangle_count
);

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("word delivered while busy");

    a_start_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_START) |=>
            busy ##1 (o_strobe && o_status == STATUS_OK && o_triangle_count == 8'd1))
        else $error("start word wrong");

    a_read_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_READ) |=>
            busy ##1 busy ##1 (o_strobe && o_hit_index == $past(i_read_index, 3)))
        else $error("read word wrong");

    a_bad_op_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(i_opcode == OP_START || i_opcode == OP_INSERT ||
                             i_opcode == OP_READ)) |=>
            (o_strobe && !busy && o_status == STATUS_MISS && o_hit_index == 7'd0))
        else $error("unknown opcode word wrong");

endmodule

bind triangle_split_insert_unit tsi_checker u_tsi_checker (.*);
`default_nettype wire
